// ----- rtl/core/dda_line_rasterizer_defines.svh -----
// assertion macros shared by the line rasterizer modules
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// checked on every clock edge outside reset
`define DDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define DDA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/dda_pkg.sv -----
// shared constants for the dda line rasterizer
package dda_pkg;

	localparam int unsigned FIELD_W         = 6;
	localparam int unsigned DEF_COORD_BITS  = 6;
	localparam int unsigned DEF_FRAC_BITS   = 16;
	localparam int unsigned QUEUE_DEPTH     = 2;

endpackage

// ----- rtl/core/dda_line_if.sv -----
// line endpoint channel
interface dda_line_if import dda_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] x_start;
	logic [FIELD_W-1:0] y_start;
	logic [FIELD_W-1:0] x_stop;
	logic [FIELD_W-1:0] y_stop;

	modport source (output valid, output x_start, output y_start, output x_stop,
		output y_stop, input ready);
	modport sink (input valid, input x_start, input y_start, input x_stop,
		input y_stop, output ready);

endinterface

// ----- rtl/core/dda_pixel_if.sv -----
// pixel result channel
interface dda_pixel_if import dda_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] pixel_x;
	logic [FIELD_W-1:0] pixel_y;
	logic               last_pixel;

	modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input last_pixel,
		output ready);

endinterface

// ----- rtl/core/dda_fifo.sv -----
// small job queue between the front and back ends
`include "dda_line_rasterizer_defines.svh"

module dda_fifo import dda_pkg::*; #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q < CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	`DDA_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count over depth")
	`DDA_ASSERT(a_count_push, (push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)), "queue count missed a push")

endmodule

// ----- rtl/core/dda_front.sv -----
// front end: takes a line and works out its step count and directions
module dda_front import dda_pkg::*; #(
	parameter int unsigned COORD_BITS = DEF_COORD_BITS,
	parameter int unsigned JOB_W      = 5 * COORD_BITS + 2
) (
	dda_line_if.sink         line,
	output logic             job_valid,
	input  logic             job_ready,
	output logic [JOB_W-1:0] job_data
);

	localparam int unsigned C = COORD_BITS;

	typedef struct packed {
		logic [C-1:0] x0;
		logic [C-1:0] y0;
		logic [C-1:0] adx;
		logic [C-1:0] ady;
		logic [C-1:0] steps;
		logic         neg_x;
		logic         neg_y;
	} job_t;

	logic [C-1:0] x0;
	logic [C-1:0] y0;
	logic [C-1:0] x1;
	logic [C-1:0] y1;
	job_t         job;

	always_comb begin
		x0        = line.x_start[C-1:0];
		y0        = line.y_start[C-1:0];
		x1        = line.x_stop[C-1:0];
		y1        = line.y_stop[C-1:0];
		job.x0    = x0;
		job.y0    = y0;
		job.neg_x = (x1 < x0);
		job.neg_y = (y1 < y0);
		job.adx   = job.neg_x ? (x0 - x1) : (x1 - x0);
		job.ady   = job.neg_y ? (y0 - y1) : (y1 - y0);
		job.steps = (job.adx > job.ady) ? job.adx : job.ady;
	end

	assign job_valid  = line.valid;
	assign line.ready = job_ready;
	assign job_data   = job;

endmodule

// ----- rtl/core/dda_back.sv -----
// back end: increment division and per-pixel accumulation
`include "dda_line_rasterizer_defines.svh"

module dda_back import dda_pkg::*; #(
	parameter int unsigned COORD_BITS = DEF_COORD_BITS,
	parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS,
	parameter int unsigned JOB_W      = 5 * COORD_BITS + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_ready,
	input  logic [JOB_W-1:0] job_data,
	dda_pixel_if.source      pixel
);

	localparam int unsigned C     = COORD_BITS;
	localparam int unsigned F     = FRAC_BITS;
	localparam int unsigned ACC_W = C + F;
	localparam int unsigned CNT_W = $clog2(F);

	typedef struct packed {
		logic [C-1:0] x0;
		logic [C-1:0] y0;
		logic [C-1:0] adx;
		logic [C-1:0] ady;
		logic [C-1:0] steps;
		logic         neg_x;
		logic         neg_y;
	} job_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_EMIT = 3'b100
	} back_state_t;

	back_state_t      state_q;
	logic             out_valid_q;
	job_t             job;
	logic             take;
	logic             emit_ld;
	logic             last;
	logic             int_x;
	logic             int_y;

	logic [ACC_W-1:0] acc_x_q;
	logic [ACC_W-1:0] acc_y_q;
	logic [ACC_W-1:0] inc_x_q;
	logic [ACC_W-1:0] inc_y_q;
	logic [C:0]       rem_x_q;
	logic [C:0]       rem_y_q;
	logic [F:0]       quo_x_q;
	logic [F:0]       quo_y_q;
	logic [C-1:0]     steps_q;
	logic [C-1:0]     idx_q;
	logic             neg_x_q;
	logic             neg_y_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic [C-1:0]     x_end_q;
	logic [C-1:0]     y_end_q;
	logic [C-1:0]     px_x_q;
	logic [C-1:0]     px_y_q;
	logic             last_q;

	logic [C:0]       rem_x_sh;
	logic [C:0]       rem_y_sh;
	logic             ge_x;
	logic             ge_y;
	logic [C:0]       rem_x_nx;
	logic [C:0]       rem_y_nx;
	logic [F:0]       quo_x_nx;
	logic [F:0]       quo_y_nx;
	logic [ACC_W-1:0] inc_x_nx;
	logic [ACC_W-1:0] inc_y_nx;
	logic [ACC_W-1:0] rnd_x;
	logic [ACC_W-1:0] rnd_y;
	logic [C-1:0]     pix_x;
	logic [C-1:0]     pix_y;

	assign job       = job_t'(job_data);
	assign job_ready = (state_q == S_IDLE);
	assign take      = job_valid && job_ready;
	assign emit_ld   = (state_q == S_EMIT) && (!out_valid_q || pixel.ready);
	assign last      = (idx_q == steps_q);
	assign int_x     = (job.adx == job.steps);
	assign int_y     = (job.ady == job.steps);

	// one quotient bit per cycle for both increments
	always_comb begin
		rem_x_sh = {rem_x_q[C-1:0], 1'b0};
		rem_y_sh = {rem_y_q[C-1:0], 1'b0};
		ge_x     = (rem_x_sh >= {1'b0, steps_q});
		ge_y     = (rem_y_sh >= {1'b0, steps_q});
		rem_x_nx = ge_x ? (rem_x_sh - {1'b0, steps_q}) : rem_x_sh;
		rem_y_nx = ge_y ? (rem_y_sh - {1'b0, steps_q}) : rem_y_sh;
		quo_x_nx = {quo_x_q[F-1:0], ge_x};
		quo_y_nx = {quo_y_q[F-1:0], ge_y};
		inc_x_nx = neg_x_q ? (ACC_W'(0) - ACC_W'(quo_x_nx)) : ACC_W'(quo_x_nx);
		inc_y_nx = neg_y_q ? (ACC_W'(0) - ACC_W'(quo_y_nx)) : ACC_W'(quo_y_nx);
	end

	// round half up
	always_comb begin
		rnd_x = acc_x_q + (ACC_W'(1) << (F - 1));
		rnd_y = acc_y_q + (ACC_W'(1) << (F - 1));
		pix_x = rnd_x[ACC_W-1:F];
		pix_y = rnd_y[ACC_W-1:F];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= (job.steps == '0) ? S_EMIT : S_DIV;
					end
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_ld && last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (pixel.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_x_q   <= {job.x0, F'(0)};
			acc_y_q   <= {job.y0, F'(0)};
			steps_q   <= job.steps;
			idx_q     <= '0;
			neg_x_q   <= job.neg_x;
			neg_y_q   <= job.neg_y;
			div_cnt_q <= CNT_W'(F - 1);
			quo_x_q   <= (F + 1)'(int_x);
			quo_y_q   <= (F + 1)'(int_y);
			rem_x_q   <= int_x ? '0 : {1'b0, job.adx};
			rem_y_q   <= int_y ? '0 : {1'b0, job.ady};
			inc_x_q   <= '0;
			inc_y_q   <= '0;
			x_end_q   <= job.neg_x ? (job.x0 - job.adx) : (job.x0 + job.adx);
			y_end_q   <= job.neg_y ? (job.y0 - job.ady) : (job.y0 + job.ady);
		end
		if (state_q == S_DIV) begin
			rem_x_q   <= rem_x_nx;
			rem_y_q   <= rem_y_nx;
			quo_x_q   <= quo_x_nx;
			quo_y_q   <= quo_y_nx;
			div_cnt_q <= div_cnt_q - CNT_W'(1);
			if (div_cnt_q == '0) begin
				inc_x_q <= inc_x_nx;
				inc_y_q <= inc_y_nx;
			end
		end
		if (emit_ld) begin
			px_x_q  <= pix_x;
			px_y_q  <= pix_y;
			last_q  <= last;
			acc_x_q <= acc_x_q + inc_x_q;
			acc_y_q <= acc_y_q + inc_y_q;
			idx_q   <= idx_q + C'(1);
		end
	end

	assign pixel.valid      = out_valid_q;
	assign pixel.pixel_x    = FIELD_W'(px_x_q);
	assign pixel.pixel_y    = FIELD_W'(px_y_q);
	assign pixel.last_pixel = last_q;

	`DDA_ASSERT(a_div_nonzero, (state_q == S_DIV) |-> (steps_q != '0), "division with zero step count")
	`DDA_ASSERT(a_last_at_end, (emit_ld && last) |-> ((pix_x == x_end_q) && (pix_y == y_end_q)), "final pixel off the endpoint")
	`DDA_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> ((state_q == S_IDLE) && !out_valid_q), "back end active in reset")

endmodule

// ----- rtl/core/dda_line_rasterizer.sv -----
// dda line rasterizer top level
// a line passes the queue and, unless of zero length, the one-bit-per-cycle
// increment divider before its first pixel; the back end takes a new line only once
// the last pixel of the previous one is loaded; one pixel per cycle while emitting
// and pixel.ready is high; the queue takes up to QUEUE_DEPTH further lines
// reset: arst_n clears the queue, the back end state and the output valid at once
module dda_line_rasterizer import dda_pkg::*; #(
	parameter int unsigned COORD_BITS = DEF_COORD_BITS,
	parameter int unsigned FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	dda_line_if.sink    line,
	dda_pixel_if.source pixel
);

	localparam int unsigned JOB_W = 5 * COORD_BITS + 2;

	logic             fj_valid;
	logic             fj_ready;
	logic [JOB_W-1:0] fj_data;
	logic             bj_valid;
	logic             bj_ready;
	logic [JOB_W-1:0] bj_data;

	dda_front #(
		.COORD_BITS (COORD_BITS),
		.JOB_W      (JOB_W)
	) u_front (
		.line      (line),
		.job_valid (fj_valid),
		.job_ready (fj_ready),
		.job_data  (fj_data)
	);

	dda_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fj_valid),
		.in_ready  (fj_ready),
		.in_data   (fj_data),
		.out_valid (bj_valid),
		.out_ready (bj_ready),
		.out_data  (bj_data)
	);

	dda_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.JOB_W      (JOB_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job_ready (bj_ready),
		.job_data  (bj_data),
		.pixel     (pixel)
	);

endmodule

// ----- verif/tb_dda_line_rasterizer.sv -----
// testbench for the dda line rasterizer: directed and random lines checked pixel by pixel
`timescale 1ns / 1ps

module tb_dda_line_rasterizer;
	import dda_pkg::*;

	localparam int unsigned COORD   = DEF_COORD_BITS;
	localparam int unsigned FRAC    = DEF_FRAC_BITS;
	localparam int          MAX_C   = (1 << COORD) - 1;
	localparam longint      HALF    = longint'(1) << (FRAC - 1);

	typedef struct packed {
		logic [FIELD_W-1:0] x;
		logic [FIELD_W-1:0] y;
		logic               last;
	} pixel_t;

	logic clk;
	logic arst_n;
	bit   idle_en;
	int   mismatches;
	int   pixels_seen;

	pixel_t pending_pixels[$];

	dda_line_if  line_ch ();
	dda_pixel_if pix_ch ();

	dda_line_rasterizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.pixel  (pix_ch)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic longint step_inc(input longint d, input longint steps);
		longint q;
		q = ((d < 0 ? -d : d) << FRAC) / steps;
		return d < 0 ? -q : q;
	endfunction

	function automatic logic [FIELD_W-1:0] snap_coord(input longint acc);
		longint v;
		v = acc + HALF;
		if (v < 0) begin
			v = 0;
		end
		return FIELD_W'((v >>> FRAC) & MAX_C);
	endfunction

	// walks the line and queues every pixel it will produce
	function automatic void trace_line(input logic [FIELD_W-1:0] xs, input logic [FIELD_W-1:0] ys,
		input logic [FIELD_W-1:0] xe, input logic [FIELD_W-1:0] ye);
		longint x0, y0, dx, dy, adx, ady, steps, xinc, yinc, xacc, yacc;
		pixel_t p;
		x0 = longint'(xs) & MAX_C;
		y0 = longint'(ys) & MAX_C;
		dx = (longint'(xe) & MAX_C) - x0;
		dy = (longint'(ye) & MAX_C) - y0;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		steps = adx > ady ? adx : ady;
		xinc = 0;
		yinc = 0;
		if (steps > 0) begin
			xinc = step_inc(dx, steps);
			yinc = step_inc(dy, steps);
		end
		xacc = x0 << FRAC;
		yacc = y0 << FRAC;
		for (longint i = 0; i <= steps; i++) begin
			p.x = snap_coord(xacc);
			p.y = snap_coord(yacc);
			p.last = (i == steps);
			pending_pixels.push_back(p);
			xacc += xinc;
			yacc += yinc;
		end
	endfunction

	task automatic send_line(input int xs, input int ys, input int xe, input int ye);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			line_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		line_ch.valid   <= 1'b1;
		line_ch.x_start <= FIELD_W'(xs);
		line_ch.y_start <= FIELD_W'(ys);
		line_ch.x_stop  <= FIELD_W'(xe);
		line_ch.y_stop  <= FIELD_W'(ye);
		do begin
			@(posedge clk);
		end while (!line_ch.ready);
		trace_line(FIELD_W'(xs), FIELD_W'(ys), FIELD_W'(xe), FIELD_W'(ye));
	endtask

	function automatic int clamp_coord(input int v);
		return v < 0 ? 0 : (v > MAX_C ? MAX_C : v);
	endfunction

	task automatic test_zero_length();
		send_line(0, 0, 0, 0);
		send_line(MAX_C, MAX_C, MAX_C, MAX_C);
		send_line(21, 42, 21, 42);
	endtask

	task automatic test_axis_lines();
		send_line(0, 0, MAX_C, 0);
		send_line(MAX_C, MAX_C, 0, MAX_C);
		send_line(0, 0, 0, MAX_C);
		send_line(MAX_C, MAX_C, MAX_C, 0);
		send_line(5, 5, 6, 5);
	endtask

	task automatic test_diagonals();
		send_line(0, 0, MAX_C, MAX_C);
		send_line(MAX_C, 0, 0, MAX_C);
		send_line(MAX_C, MAX_C, 0, 0);
		send_line(5, 5, 4, 6);
	endtask

	task automatic test_octants();
		send_line(10, 10, 40, 20);
		send_line(40, 20, 10, 10);
		send_line(10, 40, 40, 30);
		send_line(10, 10, 20, 40);
		send_line(20, 40, 10, 10);
		send_line(30, 5, 25, 60);
		send_line(60, 50, 2, 49);
	endtask

	// half-pixel and truncated increments
	task automatic test_rounding();
		send_line(0, 0, 2, 1);
		send_line(0, 1, 2, 0);
		send_line(0, 0, 3, 1);
		send_line(3, 2, 0, 0);
	endtask

	task automatic test_random_lines(input int count);
		int xs, ys;
		for (int n = 0; n < count; n++) begin
			xs = $urandom_range(0, MAX_C);
			ys = $urandom_range(0, MAX_C);
			case ($urandom_range(0, 4))
				0, 1: begin
					send_line(xs, ys, $urandom_range(0, MAX_C), $urandom_range(0, MAX_C));
				end
				2: begin
					send_line(xs, ys, clamp_coord(xs + $urandom_range(0, 8) - 4),
						clamp_coord(ys + $urandom_range(0, 8) - 4));
				end
				3: begin
					send_line(xs, ys, xs, $urandom_range(0, MAX_C));
				end
				default: begin
					send_line(xs, ys, $urandom_range(0, MAX_C), ys);
				end
			endcase
		end
	endtask

	// sink side stalls in bursts
	initial begin
		int stall_left;
		stall_left = 0;
		pix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				pix_ch.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				pix_ch.ready <= 1'b0;
			end else begin
				pix_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
					pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.last_pixel));
			end else begin
				want = pending_pixels.pop_front();
				if (pix_ch.pixel_x !== want.x || pix_ch.pixel_y !== want.y
					|| pix_ch.last_pixel !== want.last) begin
					report_mismatch($sformatf("pixel %0d got (%0d,%0d,%0b) want (%0d,%0d,%0b)",
						pixels_seen, pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.last_pixel,
						want.x, want.y, want.last));
				end
			end
		end
	end

	initial begin
		#8ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		mismatches  = 0;
		pixels_seen = 0;
		idle_en     = 1'b1;
		arst_n      = 1'b0;
		line_ch.valid   <= 1'b0;
		line_ch.x_start <= '0;
		line_ch.y_start <= '0;
		line_ch.x_stop  <= '0;
		line_ch.y_stop  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_length();
		test_axis_lines();
		test_diagonals();
		test_octants();
		test_rounding();
		test_random_lines(60);
		idle_en = 1'b0;
		test_random_lines(20);
		line_ch.valid <= 1'b0;

		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (FRAC + 8) @(posedge clk);
		if (mismatches == 0 && pending_pixels.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/dda_pkg.sv
rtl/core/dda_line_if.sv
rtl/core/dda_pixel_if.sv
rtl/core/dda_fifo.sv
rtl/core/dda_front.sv
rtl/core/dda_back.sv
rtl/core/dda_line_rasterizer.sv
verif/tb_dda_line_rasterizer.sv
